// ===== rtl/core/address_range_access_firewall_assert.svh =====
// Assertion macros used by the firewall back end (afw_back).
`ifndef ADDRESS_RANGE_ACCESS_FIREWALL_ASSERT_SVH
`define ADDRESS_RANGE_ACCESS_FIREWALL_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define AFW_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define AFW_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/afw_pkg.sv =====
// Shared types and constants of the address range access firewall.
package afw_pkg;

  localparam int ADDR_W = 64;
  localparam int DEV_W = 8;
  localparam int RIDX_W = 5;
  localparam int LIMIT_W = 16;
  localparam int TALLY_W = 17;
  localparam int Q_DEPTH = 2;

  localparam logic [LIMIT_W-1:0] RATE_LIMIT_RESET = 16'd1000;

  localparam logic [1:0] OP_CHECK = 2'd0;
  localparam logic [1:0] OP_RULE = 2'd1;
  localparam logic [1:0] OP_QUAR = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [1:0] VERDICT_ALLOW = 2'd0;
  localparam logic [1:0] VERDICT_DENY = 2'd1;
  localparam logic [1:0] VERDICT_RATE = 2'd2;
  localparam logic [1:0] VERDICT_QUAR = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic dev_ok;
    logic rule_ok;
    logic [ADDR_W-1:0] address;
    logic [DEV_W-1:0] device;
    logic write_access;
    logic [RIDX_W-1:0] rule_index;
    logic [ADDR_W-1:0] range_start;
    logic [ADDR_W-1:0] range_end;
    logic block_writes;
    logic block_reads;
  } item_t;

endpackage

// ===== rtl/core/afw_front.sv =====
// Front end: accepts beats and classifies them into queue entries.
module afw_front
  import afw_pkg::*;
#(
  parameter int RULE_COUNT = 32,
  parameter int DEVICE_COUNT = 256
) (
  input  logic start,
  input  logic busy,
  input  logic [1:0] kind,
  input  logic [ADDR_W-1:0] address,
  input  logic [DEV_W-1:0] device,
  input  logic write_access,
  input  logic [RIDX_W-1:0] rule_index,
  input  logic [ADDR_W-1:0] range_start,
  input  logic [ADDR_W-1:0] range_end,
  input  logic block_writes,
  input  logic block_reads,
  output logic push,
  output item_t push_item
);

  always_comb begin
    push = start && !busy && (kind != OP_NONE);
    push_item.op = kind;
    push_item.dev_ok = (32'(device) < DEVICE_COUNT);
    push_item.rule_ok = (32'(rule_index) < RULE_COUNT);
    push_item.address = address;
    push_item.device = device;
    push_item.write_access = write_access;
    push_item.rule_index = rule_index;
    push_item.range_start = range_start;
    push_item.range_end = range_end;
    push_item.block_writes = block_writes;
    push_item.block_reads = block_reads;
  end

endmodule

// ===== rtl/core/afw_queue.sv =====
// Two-entry queue between front end and back end.
module afw_queue
  import afw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  item_t push_item,
  output logic full,
  input  logic pop,
  output logic valid,
  output item_t head
);

  localparam int PTR_W = $clog2(Q_DEPTH);

  item_t entries [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0] count;

  assign full = (count == (PTR_W+1)'(Q_DEPTH));
  assign valid = (count != '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/core/afw_back.sv =====
// Back end: rule lanes, per-device memory read-modify-write, verdicts.
`include "address_range_access_firewall_assert.svh"

module afw_back
  import afw_pkg::*;
#(
  parameter int RULE_COUNT = 32,
  parameter int DEVICE_COUNT = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic [LIMIT_W-1:0] rate_limit,
  input  logic q_valid,
  input  item_t q_item,
  output logic pop,
  output logic clearing,
  output logic done,
  output logic [1:0] verdict
);

  localparam int DW = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
  localparam int MW = RULE_COUNT + 1 + TALLY_W;

  localparam logic ST_CLEAR = 1'b0;
  localparam logic ST_RUN = 1'b1;

  logic state;
  logic [DW-1:0] clr_idx;

  // per-device word: {rule mask, quarantined, tally}
  logic [MW-1:0] mem [DEVICE_COUNT];
  logic [MW-1:0] rdata;
  logic mem_we;
  logic [DW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;

  logic [ADDR_W-1:0] rule_low [RULE_COUNT];
  logic [ADDR_W-1:0] rule_high [RULE_COUNT];
  logic [RULE_COUNT-1:0] rule_on;
  logic [RULE_COUNT-1:0] rule_no_write;
  logic [RULE_COUNT-1:0] rule_no_read;

  logic [RULE_COUNT-1:0] hit;
  logic [RULE_COUNT-1:0] dir_deny;

  logic b_valid;
  logic [1:0] b_op;
  logic b_dev_ok;
  logic b_rule_ok;
  logic [DW-1:0] b_idx;
  logic [RIDX_W-1:0] b_ri;

  logic [TALLY_W-1:0] rd_tally;
  logic rd_quar;
  logic [RULE_COUNT-1:0] rd_mask;
  logic [RULE_COUNT-1:0] mask_eff;
  logic over;
  logic deny_any;
  logic [1:0] verdict_next;
  logic [MW-1:0] word_next;

  assign clearing = (state == ST_CLEAR);
  assign pop = q_valid && !b_valid && (state == ST_RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_idx <= '0;
    end else if (state == ST_CLEAR) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == DW'(DEVICE_COUNT - 1)) begin
        state <= ST_RUN;
      end
    end
  end

  for (genvar r = 0; r < RULE_COUNT; r++) begin : g_lane
    always_ff @(posedge clk) begin
      if (rst) begin
        rule_on[r] <= 1'b0;
      end else if (pop && q_item.op == OP_RULE && q_item.rule_ok &&
                   32'(q_item.rule_index) == r) begin
        rule_on[r] <= 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (pop && q_item.op == OP_RULE && q_item.rule_ok &&
          32'(q_item.rule_index) == r) begin
        rule_low[r] <= q_item.range_start;
        rule_high[r] <= q_item.range_end;
        rule_no_write[r] <= q_item.block_writes;
        rule_no_read[r] <= q_item.block_reads;
      end
    end

    always_ff @(posedge clk) begin
      if (pop) begin
        hit[r] <= rule_on[r] && (q_item.address >= rule_low[r]) &&
                  (q_item.address <= rule_high[r]);
        dir_deny[r] <= q_item.write_access ? rule_no_write[r] : rule_no_read[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_op <= q_item.op;
      b_dev_ok <= q_item.dev_ok;
      b_rule_ok <= q_item.rule_ok;
      b_idx <= DW'(q_item.device);
      b_ri <= q_item.rule_index;
      rdata <= mem[DW'(q_item.device)];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_comb begin
    rd_tally = rdata[TALLY_W-1:0];
    rd_quar = rdata[TALLY_W];
    rd_mask = rdata[MW-1:TALLY_W+1];
    mask_eff = b_dev_ok ? rd_mask : '0;
    over = ({1'b0, rate_limit} < rd_tally);
    deny_any = |(hit & (dir_deny | ~mask_eff));

    priority if (b_dev_ok && rd_quar) begin
      verdict_next = VERDICT_QUAR;
    end else if (b_dev_ok && over) begin
      verdict_next = VERDICT_RATE;
    end else if (deny_any) begin
      verdict_next = VERDICT_DENY;
    end else begin
      verdict_next = VERDICT_ALLOW;
    end

    word_next = rdata;
    unique case (b_op)
      OP_CHECK: begin
        if (!rd_quar && !over) begin
          word_next[TALLY_W-1:0] = TALLY_W'(rd_tally + 1'b1);
        end
      end
      OP_RULE: begin
        if (b_rule_ok) begin
          word_next[MW-1:TALLY_W+1] = rd_mask | (RULE_COUNT'(1) << b_ri);
        end
      end
      OP_QUAR: begin
        word_next[TALLY_W] = 1'b1;
      end
      default: begin
        word_next = rdata;
      end
    endcase

    mem_we = (state == ST_CLEAR) || (b_valid && b_dev_ok);
    mem_waddr = (state == ST_CLEAR) ? clr_idx : b_idx;
    mem_wdata = (state == ST_CLEAR) ? '0 : word_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= b_valid && (b_op == OP_CHECK);
    end
  end

  always_ff @(posedge clk) begin
    verdict <= verdict_next;
  end

  `AFW_ASSERT_SAME(a_no_pop_in_b, b_valid, !pop, "pop while a beat is in stage B")
  `AFW_ASSERT_SAME(a_idle_clear, state == ST_CLEAR, !pop && !b_valid,
    "beat in flight during clearing pass")
  `AFW_ASSERT_NEXT(a_pop_to_b, pop, b_valid, "popped beat did not reach stage B")
  `AFW_ASSERT_SAME(a_done_gap, done, !b_valid, "verdict overlaps next stage B beat")

endmodule

// ===== rtl/core/address_range_access_firewall.sv =====
// Top level of the address range access firewall.
//
//   channel   signals                                   handshake
//   -------   ---------------------------------------   -----------------------
//   item in   kind address device write_access          start && !busy
//             rule_index range_start range_end
//             block_writes block_reads
//   result    verdict                                   done, one cycle strobe
//   config    cfg_wdata (rate_limit)                    cfg_we
//
// In the back end an item passes a per-device memory read, then verdict and write
// back. While busy is low the front takes one beat a cycle into a 2-entry queue.
// A check's verdict and done are registered from stage B, which follows its pop;
// an item may wait in the queue before its pop. busy stays high after reset while
// the device memory clears, and while the queue is full; results cannot be stalled.
module address_range_access_firewall
  import afw_pkg::*;
#(
  parameter int RULE_COUNT = 32,
  parameter int DEVICE_COUNT = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] kind,
  input  logic [ADDR_W-1:0] address,
  input  logic [DEV_W-1:0] device,
  input  logic write_access,
  input  logic [RIDX_W-1:0] rule_index,
  input  logic [ADDR_W-1:0] range_start,
  input  logic [ADDR_W-1:0] range_end,
  input  logic block_writes,
  input  logic block_reads,
  output logic done,
  output logic [1:0] verdict,
  input  logic cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  logic [LIMIT_W-1:0] rate_limit;
  logic push;
  item_t push_item;
  logic q_full;
  logic q_valid;
  item_t q_item;
  logic pop;
  logic clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_limit <= RATE_LIMIT_RESET;
    end else if (cfg_we) begin
      rate_limit <= cfg_wdata;
    end
  end

  assign busy = q_full || clearing;

  afw_front #(
    .RULE_COUNT(RULE_COUNT),
    .DEVICE_COUNT(DEVICE_COUNT)
  ) u_front (
    .start(start),
    .busy(busy),
    .kind(kind),
    .address(address),
    .device(device),
    .write_access(write_access),
    .rule_index(rule_index),
    .range_start(range_start),
    .range_end(range_end),
    .block_writes(block_writes),
    .block_reads(block_reads),
    .push(push),
    .push_item(push_item)
  );

  afw_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_item(push_item),
    .full(q_full),
    .pop(pop),
    .valid(q_valid),
    .head(q_item)
  );

  afw_back #(
    .RULE_COUNT(RULE_COUNT),
    .DEVICE_COUNT(DEVICE_COUNT)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .rate_limit(rate_limit),
    .q_valid(q_valid),
    .q_item(q_item),
    .pop(pop),
    .clearing(clearing),
    .done(done),
    .verdict(verdict)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for address_range_access_firewall: directed and random beats.
`timescale 1ns / 1ps

module testbench
  import afw_pkg::*;
();

  localparam int RULES = 32;
  localparam int DEVICES = 256;
  localparam int SETTLE_CYCLES = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int POOL_SIZE = 24;

  typedef struct {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] address;
    logic [DEV_W-1:0]  device;
    logic              write_access;
    logic [RIDX_W-1:0] rule_index;
    logic [ADDR_W-1:0] range_start;
    logic [ADDR_W-1:0] range_end;
    logic              block_writes;
    logic              block_reads;
  } fw_beat_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] kind;
  logic [ADDR_W-1:0] address;
  logic [DEV_W-1:0] device;
  logic write_access;
  logic [RIDX_W-1:0] rule_index;
  logic [ADDR_W-1:0] range_start;
  logic [ADDR_W-1:0] range_end;
  logic block_writes;
  logic block_reads;
  logic done;
  logic [1:0] verdict;
  logic cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  // firewall state as the testbench sees it
  logic [ADDR_W-1:0]  fw_lo [RULES];
  logic [ADDR_W-1:0]  fw_hi [RULES];
  logic [DEVICES-1:0] fw_mask [RULES];
  logic               fw_on [RULES];
  logic               fw_no_wr [RULES];
  logic               fw_no_rd [RULES];
  logic               fw_quar [DEVICES];
  logic [TALLY_W-1:0] fw_tally [DEVICES];
  logic [LIMIT_W-1:0] fw_limit;

  logic [1:0] verdicts_due [$];
  logic [DEV_W-1:0] dev_pool [POOL_SIZE];
  bit gaps_on;
  int fails = 0;
  int idle_cycles = 0;

  address_range_access_firewall dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .address(address),
    .device(device), .write_access(write_access), .rule_index(rule_index),
    .range_start(range_start), .range_end(range_end), .block_writes(block_writes),
    .block_reads(block_reads), .done(done), .verdict(verdict), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic fw_beat_t beat_of(logic [1:0] k, logic [ADDR_W-1:0] a,
                                       logic [DEV_W-1:0] d, logic wr,
                                       logic [RIDX_W-1:0] ri, logic [ADDR_W-1:0] lo,
                                       logic [ADDR_W-1:0] hi, logic bw, logic br);
    fw_beat_t b;
    b.kind = k;
    b.address = a;
    b.device = d;
    b.write_access = wr;
    b.rule_index = ri;
    b.range_start = lo;
    b.range_end = hi;
    b.block_writes = bw;
    b.block_reads = br;
    return b;
  endfunction

  // Applies one beat to the firewall state; gives is set when a verdict is owed.
  function automatic void firewall_apply(input fw_beat_t b, output bit gives,
                                         output logic [1:0] v);
    gives = 1'b0;
    v = VERDICT_ALLOW;
    case (b.kind)
      OP_CHECK: begin
        gives = 1'b1;
        if (fw_quar[b.device]) begin
          v = VERDICT_QUAR;
        end else if (fw_tally[b.device] > {1'b0, fw_limit}) begin
          v = VERDICT_RATE;
        end else begin
          fw_tally[b.device] = fw_tally[b.device] + 1'b1;
          for (int r = 0; r < RULES; r++) begin
            if (fw_on[r] && b.address >= fw_lo[r] && b.address <= fw_hi[r]) begin
              if (!fw_mask[r][b.device] || (b.write_access && fw_no_wr[r]) ||
                  (!b.write_access && fw_no_rd[r]))
                v = VERDICT_DENY;
            end
          end
        end
      end
      OP_RULE: begin
        fw_lo[b.rule_index] = b.range_start;
        fw_hi[b.rule_index] = b.range_end;
        fw_mask[b.rule_index][b.device] = 1'b1;
        fw_on[b.rule_index] = 1'b1;
        fw_no_wr[b.rule_index] = b.block_writes;
        fw_no_rd[b.rule_index] = b.block_reads;
      end
      OP_QUAR: begin
        fw_quar[b.device] = 1'b1;
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_beat(input fw_beat_t b);
    int unsigned gap;
    bit gives;
    logic [1:0] v;
    gap = gaps_on ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    kind = b.kind;
    address = b.address;
    device = b.device;
    write_access = b.write_access;
    rule_index = b.rule_index;
    range_start = b.range_start;
    range_end = b.range_end;
    block_writes = b.block_writes;
    block_reads = b.block_reads;
    start = 1'b1;
    do @(posedge clk); while (busy);
    firewall_apply(b, gives, v);
    if (gives) verdicts_due.push_back(v);
  endtask

  // beats that give no verdict may still be in the pipe, hence the settle time
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_rate_limit(input logic [LIMIT_W-1:0] lim);
    wait_idle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = lim;
    @(negedge clk);
    cfg_we = 1'b0;
    fw_limit = lim;
  endtask

  task automatic test_directed();
    logic [ADDR_W-1:0] top;
    top = '1;
    gaps_on = 1'b1;
    send_beat(beat_of(OP_CHECK, '0, 8'd0, 1'b0, '0, '0, '0, 1'b0, 1'b0));
    send_beat(beat_of(OP_CHECK, top, 8'd255, 1'b1, '1, top, top, 1'b1, 1'b1));
    send_beat(beat_of(OP_RULE, '0, 8'd5, 1'b0, 5'd0, 64'h1000, 64'h1fff, 1'b1, 1'b0));
    send_beat(beat_of(OP_CHECK, 64'h1000, 8'd5, 1'b0, '0, '0, '0, 1'b0, 1'b0));
    send_beat(beat_of(OP_CHECK, 64'h1000, 8'd5, 1'b1, '0, '0, '0, 1'b0, 1'b0));
    send_beat(beat_of(OP_CHECK, 64'h1fff, 8'd6, 1'b0, '0, '0, '0, 1'b0, 1'b0));
    send_beat(beat_of(OP_CHECK, 64'h2000, 8'd6, 1'b0, '0, '0, '0, 1'b0, 1'b0));
    send_beat(beat_of(OP_CHECK, 64'h0fff, 8'd6, 1'b1, '0, '0, '0, 1'b0, 1'b0));
    // same slot again: mask keeps dev 5, flags flip
    send_beat(beat_of(OP_RULE, '0, 8'd6, 1'b0, 5'd0, 64'h1000, 64'h1fff, 1'b0, 1'b1));
    send_beat(beat_of(OP_CHECK, 64'h1800, 8'd5, 1'b0, '0, '0, '0, 1'b0, 1'b0));
    send_beat(beat_of(OP_CHECK, 64'h1800, 8'd5, 1'b1, '0, '0, '0, 1'b0, 1'b0));
    send_beat(beat_of(OP_CHECK, 64'h1800, 8'd6, 1'b1, '0, '0, '0, 1'b0, 1'b0));
    send_beat(beat_of(OP_RULE, '0, 8'd255, 1'b0, 5'd31, top, top, 1'b0, 1'b0));
    send_beat(beat_of(OP_CHECK, top, 8'd255, 1'b0, '0, '0, '0, 1'b0, 1'b0));
    send_beat(beat_of(OP_CHECK, top, 8'd0, 1'b1, '0, '0, '0, 1'b0, 1'b0));
    // reversed range never matches
    send_beat(beat_of(OP_RULE, '0, 8'd1, 1'b0, 5'd3, 64'h9000, 64'h8000, 1'b1, 1'b1));
    send_beat(beat_of(OP_CHECK, 64'h8800, 8'd2, 1'b0, '0, '0, '0, 1'b0, 1'b0));
    send_beat(beat_of(OP_NONE, top, 8'd7, 1'b1, '1, top, top, 1'b1, 1'b1));
    send_beat(beat_of(OP_QUAR, '0, 8'd7, 1'b0, '0, '0, '0, 1'b0, 1'b0));
    send_beat(beat_of(OP_CHECK, 64'h1000, 8'd7, 1'b0, '0, '0, '0, 1'b0, 1'b0));
    send_beat(beat_of(OP_CHECK, 64'h9000, 8'd8, 1'b0, '0, '0, '0, 1'b0, 1'b0));
  endtask

  task automatic test_rate_limit();
    gaps_on = 1'b0;
    set_rate_limit(16'd0);
    send_beat(beat_of(OP_CHECK, 64'h1000, 8'd5, 1'b0, '0, '0, '0, 1'b0, 1'b0));
    send_beat(beat_of(OP_CHECK, 64'h1000, 8'd7, 1'b0, '0, '0, '0, 1'b0, 1'b0));
    repeat (2) send_beat(beat_of(OP_CHECK, 64'h40, 8'd100, 1'b0, '0, '0, '0, 1'b0, 1'b0));
    set_rate_limit(16'd3);
    repeat (6) send_beat(beat_of(OP_CHECK, 64'h1000, 8'd101, 1'b1, '0, '0, '0, 1'b0, 1'b0));
    set_rate_limit(16'hffff);
    repeat (4) send_beat(beat_of(OP_CHECK, 64'h1000, 8'd101, 1'b1, '0, '0, '0, 1'b0, 1'b0));
  endtask

  task automatic test_random();
    logic [LIMIT_W-1:0] limits [5];
    fw_beat_t b;
    int unsigned pick;
    int unsigned r;
    limits[0] = 16'hffff;
    limits[1] = 16'd12;
    limits[2] = 16'($urandom_range(0, 65535));
    limits[3] = 16'd0;
    limits[4] = 16'd1000;
    foreach (dev_pool[i]) dev_pool[i] = 8'($urandom_range(0, 255));
    for (int p = 0; p < 5; p++) begin
      set_rate_limit(limits[p]);
      gaps_on = (p != 2);
      for (int n = 0; n < 170; n++) begin
        b = beat_of(2'($urandom_range(0, 3)), {$urandom, $urandom}, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)), {$urandom, $urandom},
                    {$urandom, $urandom}, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 99);
        b.kind = (pick < 68) ? OP_CHECK : (pick < 88) ? OP_RULE : (pick < 94) ? OP_QUAR : OP_NONE;
        if (b.kind != OP_QUAR && $urandom_range(0, 3) != 0)
          b.device = dev_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (b.kind == OP_RULE && $urandom_range(0, 6) != 0)
          b.range_end = b.range_start + 64'($urandom_range(0, 4095));
        if (b.kind == OP_CHECK && $urandom_range(0, 9) < 7) begin
          r = $urandom_range(0, RULES - 1);
          case ($urandom_range(0, 4))
            0: b.address = fw_lo[r];
            1: b.address = fw_hi[r];
            2: b.address = fw_lo[r] - 1'b1;
            3: b.address = fw_hi[r] + 1'b1;
            default: b.address = fw_lo[r] + 64'($urandom_range(0, 4095));
          endcase
        end
        send_beat(b);
      end
    end
  endtask

  always @(posedge clk) begin : verdict_check
    logic [1:0] want;
    if (!rst && done) begin
      if (verdicts_due.size() == 0) begin
        $error("verdict: none expected, got %0d", verdict);
        fails++;
      end else begin
        want = verdicts_due.pop_front();
        if (verdict !== want) begin
          $error("verdict: expected %0d, got %0d", want, verdict);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    kind = OP_CHECK;
    address = '0;
    device = '0;
    write_access = 1'b0;
    rule_index = '0;
    range_start = '0;
    range_end = '0;
    block_writes = 1'b0;
    block_reads = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    fw_limit = RATE_LIMIT_RESET;
    for (int r = 0; r < RULES; r++) begin
      fw_lo[r] = '0;
      fw_hi[r] = '0;
      fw_mask[r] = '0;
      fw_on[r] = 1'b0;
      fw_no_wr[r] = 1'b0;
      fw_no_rd[r] = 1'b0;
    end
    for (int d = 0; d < DEVICES; d++) begin
      fw_quar[d] = 1'b0;
      fw_tally[d] = '0;
    end
    repeat (8) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_rate_limit();
    test_random();
    wait_idle();
    if (fails == 0 && verdicts_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
